/* hw/rtl/ecc_pkg.sv */
// elevator call controller package: command, mode and drive codes
// plus the command/status structs between controller and datapath
// no dependencies
package ecc_pkg;

  localparam logic [2:0] CMD_START       = 3'd0;
  localparam logic [2:0] CMD_CALL        = 3'd1;
  localparam logic [2:0] CMD_STOP_PRESS  = 3'd2;
  localparam logic [2:0] CMD_STOP_REL    = 3'd3;
  localparam logic [2:0] CMD_FLOOR       = 3'd4;
  localparam logic [2:0] CMD_DOOR_TO     = 3'd5;
  localparam logic [2:0] CMD_CHECK       = 3'd6;
  localparam logic [2:0] CMD_TICK        = 3'd7;

  localparam logic [2:0] MODE_INIT       = 3'd0;
  localparam logic [2:0] MODE_CHECK      = 3'd1;
  localparam logic [2:0] MODE_MOVING     = 3'd2;
  localparam logic [2:0] MODE_DOOR       = 3'd3;
  localparam logic [2:0] MODE_STOP       = 3'd4;
  localparam logic [2:0] MODE_REL_AT     = 3'd5;
  localparam logic [2:0] MODE_REL_BTW    = 3'd6;

  localparam logic [1:0] DRV_STOP        = 2'd0;
  localparam logic [1:0] DRV_UP          = 2'd1;
  localparam logic [1:0] DRV_DOWN        = 2'd2;

  localparam logic [1:0] BTN_CAB         = 2'd0;
  localparam logic [1:0] BTN_UP          = 2'd1;
  localparam logic [1:0] BTN_DOWN        = 2'd2;

  localparam logic [15:0] DOOR_TICKS_RST = 16'd3000;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_EXEC,
    OP_PRE,
    OP_STEP_AHEAD,
    OP_MOVE,
    OP_BEHIND_INIT,
    OP_STEP_BEHIND,
    OP_REVERSE,
    OP_SET_CHECK,
    OP_EMIT
  } ecc_op_e;

  typedef struct packed {
    ecc_op_e op;
  } ecc_cmd_t;

  typedef struct packed {
    logic check_go;
    logic pre_abort;
    logic pre_served;
    logic in_range;
    logic hit;
    logic out_free;
  } ecc_status_t;

endpackage

/* hw/rtl/ecc_ctrl.sv */
// elevator call controller sequencer
// walks each request through execute, call-here, ahead and behind scans
// depends on ecc_pkg
module ecc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ecc_pkg::ecc_status_t status_i,
  output ecc_pkg::ecc_cmd_t    cmd_o
);
  import ecc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_PRE    = 3'd2;
  localparam logic [2:0] S_AHEAD  = 3'd3;
  localparam logic [2:0] S_BEHIND = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.op = OP_EXEC;
        state_d = status_i.check_go ? S_PRE : S_DONE;
      end
      S_PRE: begin
        cmd_o.op = OP_PRE;
        state_d = (status_i.pre_abort || status_i.pre_served) ? S_DONE : S_AHEAD;
      end
      S_AHEAD: begin
        if (!status_i.in_range) begin
          cmd_o.op = OP_BEHIND_INIT;
          state_d = S_BEHIND;
        end else if (status_i.hit) begin
          cmd_o.op = OP_MOVE;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_STEP_AHEAD;
        end
      end
      S_BEHIND: begin
        if (!status_i.in_range) begin
          cmd_o.op = OP_SET_CHECK;
          state_d = S_DONE;
        end else if (status_i.hit) begin
          cmd_o.op = OP_REVERSE;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_STEP_BEHIND;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_load_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_EXEC))
    else $error("load did not start execution");
  a_scan_from_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AHEAD) |-> ($past(state_q) == S_PRE || $past(state_q) == S_AHEAD))
    else $error("ahead scan entered out of order");
  a_emit_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT) |-> (state_q == S_DONE && status_i.out_free))
    else $error("emit outside done");
`endif

endmodule

/* hw/rtl/ecc_dp.sv */
// elevator call controller datapath: call flags, car state, door timer,
// scan index and the output register
// depends on ecc_pkg
module ecc_dp #(
  parameter int FLOOR_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [2:0]          in_command_i,
  input  logic                in_at_floor_i,
  input  logic [1:0]          in_sensed_floor_i,
  input  logic [1:0]          in_button_kind_i,
  input  ecc_pkg::ecc_cmd_t   cmd_i,
  output ecc_pkg::ecc_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          motor_drive_o,
  output logic                door_lamp_o,
  output logic                stop_lamp_o,
  output logic [1:0]          floor_indicator_o,
  output logic [2:0]          controller_mode_o,
  output logic                floor_served_o,
  output logic [1:0]          served_floor_o,
  output logic                door_timed_out_o
);
  import ecc_pkg::*;

  localparam int FW = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
  localparam int IW = $clog2(FLOOR_COUNT + 1) + 1;

  logic [15:0] ticks_q;
  logic [2:0]  command_q;
  logic        at_q;
  logic [1:0]  flr_q, kind_q;

  logic [2:0]  mode_q, mode_d;
  logic [FLOOR_COUNT-1:0] cab_q, cab_d, up_q, up_d, dn_q, dn_d;
  logic [1:0]  lf_q, lf_d;
  logic        gu_q, gu_d, lgu_q, lgu_d, en_q, en_d, run_q, run_d;
  logic [15:0] timer_q, timer_d;
  logic [1:0]  motor_q, motor_d, ind_q, ind_d;
  logic        door_q, door_d, stop_q, stop_d;
  logic        served_q, served_d;
  logic [1:0]  sfloor_q, sfloor_d;
  logic [IW-1:0] idx_q, idx_d;

  logic        out_valid_q;
  logic [1:0]  o_motor_q, o_ind_q, o_sfloor_q;
  logic        o_door_q, o_stop_q, o_served_q, o_to_q;
  logic [2:0]  o_mode_q;

  logic [FLOOR_COUNT-1:0] any_vec, flr_bit, lf_bit, dirset, oppset;
  logic        timed_out, here, any_at, idx_is_lf;
  logic [IW-1:0] lf_x, dir_x;
  logic        behind_hit, in_behind_q, hit_sel;

  assign any_vec   = cab_q | up_q | dn_q;
  assign flr_bit   = FLOOR_COUNT'(1) << flr_q;
  assign lf_bit    = FLOOR_COUNT'(1) << lf_q;
  assign dirset    = gu_q ? up_q : dn_q;
  assign oppset    = gu_q ? dn_q : up_q;
  assign timed_out = run_q && (timer_q >= ticks_q);
  assign here      = |((cab_q | dirset) & lf_bit);
  assign lf_x      = IW'(lf_q);
  assign dir_x     = gu_q ? IW'(1) : {IW{1'b1}};
  assign idx_is_lf = (idx_q == lf_x);
  assign any_at    = any_vec[idx_q[FW-1:0]];

  // behind-scan hit at the own floor only counts an opposite-direction call
  assign behind_hit = at_q ? ((!idx_is_lf && any_at) || (idx_is_lf && |(oppset & lf_bit)))
                           : any_at;

  // the controller reads one hit line; select the rule for the scan in progress
  assign hit_sel = in_behind_q ? behind_hit : any_at;

  always_comb begin
    status_o.check_go  = (command_q == CMD_CHECK) &&
                         (mode_q inside {MODE_CHECK, MODE_REL_AT, MODE_REL_BTW});
    status_o.pre_abort = (mode_q == MODE_REL_AT && !timed_out) ||
                         (mode_q == MODE_REL_BTW && any_vec == '0);
    status_o.pre_served = !status_o.pre_abort && at_q && here;
    status_o.in_range  = !idx_q[IW-1] && (idx_q < IW'(FLOOR_COUNT));
    status_o.out_free  = !out_valid_q || out_ready_i;
    status_o.hit       = hit_sel;
  end

  logic [1:0] flr_c;
  assign flr_c = (in_sensed_floor_i >= FLOOR_COUNT) ? 2'(FLOOR_COUNT - 1) : in_sensed_floor_i;

  always_comb begin
    mode_d = mode_q; cab_d = cab_q; up_d = up_q; dn_d = dn_q; lf_d = lf_q;
    gu_d = gu_q; lgu_d = lgu_q; en_d = en_q; run_d = run_q; timer_d = timer_q;
    motor_d = motor_q; ind_d = ind_q; door_d = door_q; stop_d = stop_q;
    served_d = served_q; sfloor_d = sfloor_q; idx_d = idx_q;
    case (cmd_i.op)
      OP_LOAD: begin
        served_d = 1'b0;
        sfloor_d = 2'd0;
      end
      OP_EXEC: begin
        case (command_q)
          CMD_START: begin
            gu_d = 1'b1;
            if (at_q) begin
              motor_d = DRV_STOP; ind_d = flr_q; lf_d = flr_q; mode_d = MODE_CHECK;
            end else begin
              motor_d = DRV_UP; mode_d = MODE_INIT;
            end
          end
          CMD_CALL: begin
            if (en_q) begin
              if (kind_q == BTN_CAB) cab_d = cab_q | flr_bit;
              else if (kind_q == BTN_UP) up_d = up_q | flr_bit;
              else if (kind_q == BTN_DOWN) dn_d = dn_q | flr_bit;
            end
          end
          CMD_STOP_PRESS: begin
            motor_d = DRV_STOP;
            stop_d = 1'b1;
            if (at_q) door_d = 1'b1;
            cab_d = '0; up_d = '0; dn_d = '0;
            en_d = 1'b0;
            if (mode_q == MODE_CHECK || mode_q == MODE_MOVING) begin
              run_d = 1'b1; timer_d = '0;
            end
            mode_d = MODE_STOP;
          end
          CMD_STOP_REL: begin
            en_d = 1'b1;
            stop_d = 1'b0;
            mode_d = at_q ? MODE_REL_AT : MODE_REL_BTW;
          end
          CMD_FLOOR: begin
            if (at_q) begin
              if (mode_q == MODE_INIT) motor_d = DRV_STOP;
              ind_d = flr_q; lf_d = flr_q; mode_d = MODE_CHECK;
            end
          end
          CMD_DOOR_TO: begin
            door_d = 1'b0; run_d = 1'b0; mode_d = MODE_CHECK;
          end
          CMD_TICK: begin
            if (run_q && timer_q != 16'hFFFF) timer_d = timer_q + 16'd1;
          end
          default: ;
        endcase
      end
      OP_PRE: begin
        if (!status_o.pre_abort) begin
          if (mode_q == MODE_REL_AT) begin
            door_d = 1'b0; run_d = 1'b0;
          end
          if (status_o.pre_served) begin
            motor_d = DRV_STOP; door_d = 1'b1; run_d = 1'b1; timer_d = '0;
            cab_d = cab_q & ~lf_bit; up_d = up_q & ~lf_bit; dn_d = dn_q & ~lf_bit;
            served_d = 1'b1; sfloor_d = lf_q; mode_d = MODE_DOOR;
          end else if (at_q) begin
            idx_d = lf_x + dir_x;
          end else if (gu_q) begin
            idx_d = lgu_q ? lf_x + IW'(1) : lf_x;
          end else begin
            idx_d = lgu_q ? lf_x : lf_x - IW'(1);
          end
        end
      end
      OP_STEP_AHEAD: idx_d = idx_q + dir_x;
      OP_MOVE: begin
        if (at_q) lgu_d = gu_q;
        motor_d = gu_q ? DRV_UP : DRV_DOWN;
        mode_d = MODE_MOVING;
      end
      OP_BEHIND_INIT: begin
        if (at_q || gu_q == lgu_q) idx_d = lf_x;
        else if (gu_q) idx_d = lf_x - IW'(1);
        else idx_d = lf_x + IW'(1);
      end
      OP_STEP_BEHIND: idx_d = idx_q - dir_x;
      OP_REVERSE: begin
        gu_d = !gu_q; mode_d = MODE_CHECK;
      end
      OP_SET_CHECK: mode_d = MODE_CHECK;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= DOOR_TICKS_RST;
      mode_q <= MODE_INIT; cab_q <= '0; up_q <= '0; dn_q <= '0; lf_q <= 2'd0;
      gu_q <= 1'b1; lgu_q <= 1'b1; en_q <= 1'b1; run_q <= 1'b0; timer_q <= '0;
      motor_q <= DRV_STOP; ind_q <= 2'd0; door_q <= 1'b0; stop_q <= 1'b0;
      served_q <= 1'b0; sfloor_q <= 2'd0; idx_q <= '0;
      out_valid_q <= 1'b0; in_behind_q <= 1'b0;
    end else begin
      if (cfg_we_i) ticks_q <= cfg_wdata_i;
      mode_q <= mode_d; cab_q <= cab_d; up_q <= up_d; dn_q <= dn_d; lf_q <= lf_d;
      gu_q <= gu_d; lgu_q <= lgu_d; en_q <= en_d; run_q <= run_d; timer_q <= timer_d;
      motor_q <= motor_d; ind_q <= ind_d; door_q <= door_d; stop_q <= stop_d;
      served_q <= served_d; sfloor_q <= sfloor_d; idx_q <= idx_d;
      if (cmd_i.op == OP_BEHIND_INIT) in_behind_q <= 1'b1;
      else if (cmd_i.op == OP_LOAD) in_behind_q <= 1'b0;
      if (cmd_i.op == OP_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      command_q <= in_command_i;
      at_q <= in_at_floor_i;
      flr_q <= flr_c;
      kind_q <= in_button_kind_i;
    end
    if (cmd_i.op == OP_EMIT) begin
      o_motor_q <= motor_q; o_door_q <= door_q; o_stop_q <= stop_q; o_ind_q <= ind_q;
      o_mode_q <= mode_q; o_served_q <= served_q; o_sfloor_q <= sfloor_q;
      o_to_q <= timed_out;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motor_drive_o     = o_motor_q;
  assign door_lamp_o       = o_door_q;
  assign stop_lamp_o       = o_stop_q;
  assign floor_indicator_o = o_ind_q;
  assign controller_mode_o = o_mode_q;
  assign floor_served_o    = o_served_q;
  assign served_floor_o    = o_sfloor_q;
  assign door_timed_out_o  = o_to_q;

endmodule

/* hw/rtl/elevator_call_controller_top.sv */
// elevator call controller top level
// instantiates ecc_ctrl and ecc_dp, depends on ecc_pkg
//
// one request per event, one status result per request. a plain event shows its
// result after execute, then emit, and the block takes the next request once it
// is back in idle. check actions add a setup step, then the ahead scan steps the
// scan index one floor at a time until a hit or until it leaves the range, and,
// if it finds no hit, the behind scan does the same; both scans use the single
// scan index of the datapath. a result waits in the sequencer until the output
// register is free.
module elevator_call_controller_top #(
  parameter int FLOOR_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // door_open_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // at_floor[0], sensed_floor[2:1], button_kind[4:3]
  input  logic [2:0]  s_axis_tuser,    // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // motor_drive[1:0], door_lamp[2], stop_lamp[3],
                                       // floor_indicator[5:4], controller_mode[8:6],
                                       // floor_served[9], served_floor[11:10],
                                       // door_timed_out[12]
);
  import ecc_pkg::*;

  ecc_cmd_t    cmd;
  ecc_status_t status;
  logic [1:0]  motor, ind, sfloor;
  logic        door, stop, served, tout;
  logic [2:0]  mode;

  ecc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ecc_dp #(.FLOOR_COUNT(FLOOR_COUNT)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .in_command_i      (s_axis_tuser),
    .in_at_floor_i     (s_axis_tdata[0]),
    .in_sensed_floor_i (s_axis_tdata[2:1]),
    .in_button_kind_i  (s_axis_tdata[4:3]),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .motor_drive_o     (motor),
    .door_lamp_o       (door),
    .stop_lamp_o       (stop),
    .floor_indicator_o (ind),
    .controller_mode_o (mode),
    .floor_served_o    (served),
    .served_floor_o    (sfloor),
    .door_timed_out_o  (tout)
  );

  assign m_axis_tdata = {3'b000, tout, sfloor, served, mode, ind, stop, door, motor};

`ifndef SYNTH
  a_served_opens_door: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && served) |-> (mode == MODE_DOOR && door && motor == DRV_STOP))
    else $error("served floor without door open");
  a_unserved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !served) |-> (sfloor == 2'd0))
    else $error("served floor set without service");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");
`endif

endmodule
